// ===== sv/vra_pkg.sv =====
// Shared types and constants for the value rank assigner.
package vra_pkg;

  localparam int VAL_W         = 32;
  localparam int IDX_W         = 6;
  localparam int CNT_W         = IDX_W + 1;
  localparam int MAX_ITEMS_DEF = 64;

  // Input word: one value of the list
  typedef struct packed {
    logic signed [VAL_W-1:0] sample_value;
    logic                    final_item;
  } in_word_t;

  // Output word: one ranked entry
  typedef struct packed {
    logic [IDX_W-1:0] rank;
    logic [IDX_W-1:0] position;
    logic             end_of_run;
    logic             overflow;
  } out_word_t;

  // Token that walks the cell chain, one cell per cycle
  typedef struct packed {
    logic                    live;
    logic                    store;
    logic                    last;
    logic [IDX_W-1:0]        pos;
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        smaller;
  } token_t;

endpackage

// ===== sv/vra_cell.sv =====
// One list entry: stored value, running rank, and a token stage to its neighbor.
module vra_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  vra_pkg::token_t         tok_in,
  output vra_pkg::token_t         tok_out,
  input  logic                    shift,
  input  logic [vra_pkg::IDX_W-1:0] rank_in,
  output logic [vra_pkg::IDX_W-1:0] rank_out
);
  import vra_pkg::*;

  logic signed [VAL_W-1:0] value;
  logic [IDX_W-1:0]        rank;
  logic                    hit_own;
  logic                    hit_past;
  logic                    is_less;
  token_t                  tok_next;

  assign hit_own  = tok_in.live && tok_in.store && (tok_in.pos == IDX_W'(CELL_IDX));
  assign hit_past = tok_in.live && tok_in.store && (tok_in.pos > IDX_W'(CELL_IDX));
  assign is_less  = value < tok_in.value;

  // Count this entry into the passing token when it is smaller
  always_comb begin
    tok_next = tok_in;
    if (hit_past && is_less) begin
      tok_next.smaller = tok_in.smaller + IDX_W'(1);
    end
  end

  // Advance the token one cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  // Store the entry, bump its rank, or shift ranks toward the output
  always_ff @(posedge clk) begin
    if (rst) begin
      rank <= '0;
    end else if (shift) begin
      rank <= rank_in;
    end else if (hit_own) begin
      rank <= tok_in.smaller;
    end else if (hit_past && !is_less) begin
      rank <= rank + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (hit_own) begin
      value <= tok_in.value;
    end
  end

  assign rank_out = rank;

endmodule

// ===== sv/value_rank_assigner.sv =====
// Top level: list loader, cell chain and ranked-word output.
//
//   channel   ports                                     direction
//   sample    sample_valid, sample_stall, sample_word   in  (value, final_item)
//   result    rank_valid, rank_stall, rank_word         out (rank, position, flags)
//
// Loading takes one word per cycle; each value walks the chain one cell per cycle.
// After the final word, input stalls while its token walks the chain to the last
// cell, then while results go out; the first result word is loaded once that
// token has left the last cell.
// Results leave one per cycle through cell 0 as ranks shift down the chain;
// a stall on the result side holds the shift.
// Reset clears all ranks, the count and the overflow flag; no clearing pass.
module value_rank_assigner #(
  parameter int MAX_ITEMS = vra_pkg::MAX_ITEMS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  vra_pkg::in_word_t  sample_word,
  output logic               rank_valid,
  input  logic               rank_stall,
  output vra_pkg::out_word_t rank_word
);
  import vra_pkg::*;

  typedef enum logic [1:0] {
    LOAD,
    DRAIN,
    EMIT
  } phase_t;

  phase_t           phase;
  logic [CNT_W-1:0] item_count;
  logic             overflow_flag;
  logic [IDX_W-1:0] emit_idx;
  logic             accept;
  logic             has_room;
  logic             load_out;
  logic             last_out;
  token_t           tok [MAX_ITEMS+1];
  logic [IDX_W-1:0] ranks [MAX_ITEMS+1];

  assign sample_stall = (phase != LOAD);
  assign accept       = sample_valid && (phase == LOAD);
  assign has_room     = item_count < CNT_W'(MAX_ITEMS);
  assign load_out     = (phase == EMIT) && (!rank_valid || !rank_stall);
  assign last_out     = ({1'b0, emit_idx} + CNT_W'(1)) == item_count;

  // Build the token for the arriving word
  assign tok[0] = '{live: accept, store: has_room, last: sample_word.final_item,
                    pos: item_count[IDX_W-1:0], value: sample_word.sample_value,
                    smaller: '0};

  assign ranks[MAX_ITEMS] = '0;

  // Chain of cells, one per list entry
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    vra_cell #(
      .CELL_IDX(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1]),
      .shift   (load_out),
      .rank_in (ranks[i+1]),
      .rank_out(ranks[i])
    );
  end

  // Sequence load, drain and emit; hold the output word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= LOAD;
      item_count    <= '0;
      overflow_flag <= 1'b0;
      emit_idx      <= '0;
      rank_valid    <= 1'b0;
    end else begin
      // Drop the taken word unless a new one replaces it
      if (rank_valid && !rank_stall && !load_out) begin
        rank_valid <= 1'b0;
      end
      unique case (phase)
        LOAD: begin
          if (accept) begin
            if (has_room) begin
              item_count <= item_count + CNT_W'(1);
            end else begin
              overflow_flag <= 1'b1;
            end
            if (sample_word.final_item) begin
              phase <= DRAIN;
            end
          end
        end
        DRAIN: begin
          if (tok[MAX_ITEMS].live && tok[MAX_ITEMS].last) begin
            phase    <= EMIT;
            emit_idx <= '0;
          end
        end
        EMIT: begin
          if (load_out) begin
            rank_valid           <= 1'b1;
            rank_word.rank       <= ranks[0];
            rank_word.position   <= emit_idx;
            rank_word.end_of_run <= last_out;
            rank_word.overflow   <= overflow_flag;
            emit_idx             <= emit_idx + IDX_W'(1);
            if (last_out) begin
              phase         <= LOAD;
              item_count    <= '0;
              overflow_flag <= 1'b0;
            end
          end
        end
        default: phase <= LOAD;
      endcase
    end
  end

endmodule
